@@ rtl/spcu_pkg.sv @@
// Shared constants, types and buffer-write/scaler structs for the sensor
// packet check and unpack block. No dependencies.
package spcu_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int PACKET_BYTES = 64;
   localparam int RESULT_LIMIT = 8;
   localparam int CHAN_LIMIT   = (MAX_CHANNELS < RESULT_LIMIT) ? MAX_CHANNELS : RESULT_LIMIT;

   localparam int HEADER_BYTES = 2;
   localparam int SAMPLE_BYTES = 3;

   localparam int ADDR_W = $clog2(PACKET_BYTES);
   localparam int CNT_W  = $clog2(PACKET_BYTES + 1);
   localparam int POS_W  = $clog2(HEADER_BYTES + SAMPLE_BYTES * CHAN_LIMIT + PACKET_BYTES + 1);
   localparam int CHAN_W = $clog2(CHAN_LIMIT + 1);

   // uv = raw * 187.5 / 8388607 in Q8.16 -> raw * 12288000 / 8388607
   localparam logic [23:0] SCALE_NUM = 24'd12288000;
   localparam logic [23:0] SCALE_DEN = 24'd8388607;

   localparam logic [3:0] CHANNEL_COUNT_RESET = 4'd8;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_CHECKSUM = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD0,
      S_RD1,
      S_RD2,
      S_RD3,
      S_SCALE,
      S_WAIT
   } state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } store_wr_type;

   typedef struct packed {
      logic               valid;
      logic signed [23:0] raw;
   } scale_in_type;

   typedef struct packed {
      logic               valid;
      logic signed [24:0] uv;
   } scale_out_type;

endpackage

@@ rtl/sensor_packet_check_and_unpack_top.sv @@
// Sensor packet check and unpack: checksum, byte buffer, sample decode.
// Depends on spcu_pkg, spcu_byte_store, spcu_scaler.
//
//   channel   ports                         handshake
//   request   req_data_byte/last_byte/time  start & !busy
//   response  rsp_*                         rsp_valid, one cycle, no stall
//   csr       csr_write_data                csr_write_enable
//
// A byte that is not last is accepted while busy stays low.
// A last byte of a bad or oversized packet gives one response the next cycle.
// A last byte of a good packet raises busy; each channel then takes three
// reads of the byte buffer, then the two-stage scaler.
// Synchronous reset clears counters and sets channel_count to 8; the buffer
// contents stay undefined. The receiver cannot stall responses.
module sensor_packet_check_and_unpack_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   input  logic [63:0]        req_packet_time,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [2:0]         rsp_channel,
   output logic signed [23:0] rsp_raw_sample,
   output logic signed [24:0] rsp_sample_uv,
   output logic               rsp_last_result,
   output logic [63:0]        rsp_time_out,
   output logic [31:0]        rsp_good_packets,
   output logic [31:0]        rsp_bad_packets,
   input  logic               csr_write_enable,
   input  logic [3:0]         csr_write_data
);

   localparam int CNT_W  = spcu_pkg::CNT_W;
   localparam int POS_W  = spcu_pkg::POS_W;
   localparam int CHAN_W = spcu_pkg::CHAN_W;
   localparam int ADDR_W = spcu_pkg::ADDR_W;

   spcu_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [7:0]          sum_ff, sum_in;
   logic                ovf_ff, ovf_in;
   logic [31:0]         accepted_ff, accepted_in;
   logic [31:0]         failed_ff, failed_in;
   logic [3:0]          cfg_ff;
   logic [CNT_W-1:0]    len_ff, len_in;
   logic [CHAN_W-1:0]   n_ff, n_in;
   logic [CHAN_W-1:0]   chan_ff, chan_in;
   logic [POS_W-1:0]    base_ff, base_in;
   logic                chan_ok_ff, chan_ok_in;
   logic [23:0]         raw_ff, raw_in;
   logic [63:0]         time_ff, time_in;

   logic                 valid_ff, valid_in;
   spcu_pkg::status_type status_ff, status_in;
   logic [2:0]           ch_ff, ch_in;
   logic signed [23:0]   raw_out_ff, raw_out_in;
   logic signed [24:0]   uv_ff, uv_in;
   logic                 last_ff, last_in;

   spcu_pkg::store_wr_type  wr;
   logic [POS_W-1:0]        rd_pos;
   logic [7:0]              rd_data;
   spcu_pkg::scale_in_type  scale_in;
   spcu_pkg::scale_out_type scale_out;

   logic       accept;
   logic       room;
   logic [3:0] n_cfg;
   logic       last_chan;
   logic [POS_W-1:0] chan_end;

   spcu_byte_store u_store (
      .clock      (clock),
      .wr         (wr),
      .rd_addr    (rd_pos[ADDR_W-1:0]),
      .rd_data_ff (rd_data)
   );

   spcu_scaler u_scaler (
      .clock     (clock),
      .reset     (reset),
      .scale_in  (scale_in),
      .scale_out (scale_out)
   );

   assign busy   = (state_ff != spcu_pkg::S_IDLE);
   assign accept = start && !busy;
   assign room   = (count_ff < CNT_W'(spcu_pkg::PACKET_BYTES));

   // zero acts as one, large values clamp
   always_comb begin
      if (cfg_ff == 4'd0) begin
         n_cfg = 4'd1;
      end else if (cfg_ff > 4'(spcu_pkg::CHAN_LIMIT)) begin
         n_cfg = 4'(spcu_pkg::CHAN_LIMIT);
      end else begin
         n_cfg = cfg_ff;
      end
   end

   assign last_chan = ((chan_ff + CHAN_W'(1)) == n_ff);
   assign chan_end  = base_ff + POS_W'(spcu_pkg::SAMPLE_BYTES);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      ovf_in      = ovf_ff;
      accepted_in = accepted_ff;
      failed_in   = failed_ff;
      len_in      = len_ff;
      n_in        = n_ff;
      chan_in     = chan_ff;
      base_in     = base_ff;
      chan_ok_in  = chan_ok_ff;
      raw_in      = raw_ff;
      time_in     = time_ff;
      valid_in    = 1'b0;
      status_in   = status_ff;
      ch_in       = ch_ff;
      raw_out_in  = raw_out_ff;
      uv_in       = uv_ff;
      last_in     = last_ff;
      wr.en       = 1'b0;
      wr.addr     = count_ff[ADDR_W-1:0];
      wr.data     = req_data_byte;
      rd_pos      = base_ff;
      scale_in.valid = 1'b0;
      scale_in.raw   = chan_ok_ff ? $signed(raw_ff) : 24'sd0;

      case (state_ff)
         spcu_pkg::S_IDLE: begin
            if (accept) begin
               wr.en = room;
               if (room) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (!req_last_byte) begin
                  sum_in = sum_ff + req_data_byte;
               end else begin
                  time_in  = req_packet_time;
                  count_in = '0;
                  sum_in   = '0;
                  ovf_in   = 1'b0;
                  ch_in      = 3'd0;
                  raw_out_in = 24'sd0;
                  uv_in      = 25'sd0;
                  last_in    = 1'b1;
                  if (ovf_ff || !room) begin
                     valid_in  = 1'b1;
                     status_in = spcu_pkg::ST_OVERFLOW;
                  end else if ((count_ff != '0) && (~sum_ff != req_data_byte)) begin
                     valid_in  = 1'b1;
                     status_in = spcu_pkg::ST_CHECKSUM;
                     failed_in = failed_ff + 32'd1;
                  end else begin
                     accepted_in = accepted_ff + 32'd1;
                     len_in      = count_ff + CNT_W'(1);
                     n_in        = CHAN_W'(n_cfg);
                     chan_in     = '0;
                     base_in     = POS_W'(spcu_pkg::HEADER_BYTES);
                     state_in    = spcu_pkg::S_RD0;
                  end
               end
            end
         end
         spcu_pkg::S_RD0: begin
            chan_ok_in = (chan_end <= POS_W'(len_ff)) &&
                         (chan_end <= POS_W'(spcu_pkg::PACKET_BYTES));
            state_in   = spcu_pkg::S_RD1;
         end
         spcu_pkg::S_RD1: begin
            rd_pos   = base_ff + POS_W'(1);
            raw_in   = {raw_ff[15:0], rd_data};
            state_in = spcu_pkg::S_RD2;
         end
         spcu_pkg::S_RD2: begin
            rd_pos   = base_ff + POS_W'(2);
            raw_in   = {raw_ff[15:0], rd_data};
            state_in = spcu_pkg::S_RD3;
         end
         spcu_pkg::S_RD3: begin
            raw_in   = {raw_ff[15:0], rd_data};
            state_in = spcu_pkg::S_SCALE;
         end
         spcu_pkg::S_SCALE: begin
            scale_in.valid = 1'b1;
            state_in       = spcu_pkg::S_WAIT;
         end
         spcu_pkg::S_WAIT: begin
            if (scale_out.valid) begin
               valid_in   = 1'b1;
               status_in  = spcu_pkg::ST_OK;
               ch_in      = 3'(chan_ff);
               raw_out_in = chan_ok_ff ? $signed(raw_ff) : 24'sd0;
               uv_in      = scale_out.uv;
               last_in    = last_chan;
               chan_in    = chan_ff + CHAN_W'(1);
               base_in    = chan_end;
               state_in   = last_chan ? spcu_pkg::S_IDLE : spcu_pkg::S_RD0;
            end
         end
         default: begin
            state_in = spcu_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= spcu_pkg::S_IDLE;
         count_ff    <= '0;
         sum_ff      <= '0;
         ovf_ff      <= 1'b0;
         accepted_ff <= '0;
         failed_ff   <= '0;
         cfg_ff      <= spcu_pkg::CHANNEL_COUNT_RESET;
         valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         ovf_ff      <= ovf_in;
         accepted_ff <= accepted_in;
         failed_ff   <= failed_in;
         valid_ff    <= valid_in;
         if (csr_write_enable) begin
            cfg_ff <= csr_write_data;
         end
      end
      len_ff     <= len_in;
      n_ff       <= n_in;
      chan_ff    <= chan_in;
      base_ff    <= base_in;
      chan_ok_ff <= chan_ok_in;
      raw_ff     <= raw_in;
      time_ff    <= time_in;
      status_ff  <= status_in;
      ch_ff      <= ch_in;
      raw_out_ff <= raw_out_in;
      uv_ff      <= uv_in;
      last_ff    <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_channel      = ch_ff;
   assign rsp_raw_sample   = raw_out_ff;
   assign rsp_sample_uv    = uv_ff;
   assign rsp_last_result  = last_ff;
   assign rsp_time_out     = time_ff;
   assign rsp_good_packets = accepted_ff;
   assign rsp_bad_packets  = failed_ff;

   a_error_is_final: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (status_ff != spcu_pkg::ST_OK)) |->
      (last_ff && (raw_out_ff == 24'sd0) && (uv_ff == 25'sd0)))
      else $error("error response not final or carries sample data");

   a_more_channels_busy: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last_ff) |=> busy)
      else $error("dropped pending channels");

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_last_byte))
      else $error("busy without a final request byte");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(spcu_pkg::PACKET_BYTES))
      else $error("byte count past buffer depth");

endmodule

@@ rtl/spcu_byte_store.sv @@
// Packet byte buffer: one write port, one read port, registered read data.
// Depends on spcu_pkg.
module spcu_byte_store (
   input  logic                        clock,
   input  spcu_pkg::store_wr_type      wr,
   input  logic [spcu_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                  rd_data_ff
);

   logic [7:0] store_mem [spcu_pkg::PACKET_BYTES];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

endmodule

@@ rtl/spcu_scaler.sv @@
// Two-stage scaler: 24-bit sample to microvolts, Q8.16, rounded half away
// from zero. Stage 1 multiplies, stage 2 divides by the constant denominator.
// Depends on spcu_pkg.
module spcu_scaler (
   input  logic                    clock,
   input  logic                    reset,
   input  spcu_pkg::scale_in_type  scale_in,
   output spcu_pkg::scale_out_type scale_out
);

   localparam logic [24:0] TWO_DEN  = {spcu_pkg::SCALE_DEN, 1'b0};
   localparam logic [25:0] FOUR_DEN = {spcu_pkg::SCALE_DEN, 2'b00};

   logic        s1_valid_ff;
   logic        s1_neg_ff;
   logic [47:0] s1_prod_ff;
   logic        s2_valid_ff;
   logic signed [24:0] s2_uv_ff;

   logic [23:0] mag;
   logic [48:0] rounded;
   logic [24:0] q_est;
   logic [25:0] rem;
   logic [24:0] q_fix;

   always_comb begin
      mag = scale_in.raw[23] ? (24'd0 - scale_in.raw) : scale_in.raw;
   end

   // divisor 2*(2^23-1) = 2^24 - 2: estimate by shift, then up to two fixes
   always_comb begin
      rounded = {s1_prod_ff, 1'b0} + {25'd0, spcu_pkg::SCALE_DEN};
      q_est   = rounded[48:24];
      rem     = {2'b00, rounded[23:0]} + {q_est, 1'b0};
      if (rem >= FOUR_DEN) begin
         q_fix = q_est + 25'd2;
      end else if (rem >= {1'b0, TWO_DEN}) begin
         q_fix = q_est + 25'd1;
      end else begin
         q_fix = q_est;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= scale_in.valid;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_neg_ff  <= scale_in.raw[23];
      s1_prod_ff <= mag * spcu_pkg::SCALE_NUM;
      s2_uv_ff   <= s1_neg_ff ? (25'sd0 - $signed(q_fix)) : $signed(q_fix);
   end

   assign scale_out.valid = s2_valid_ff;
   assign scale_out.uv    = s2_uv_ff;

endmodule
